### src/ordered_queue_remove_by_key_defines.svh
// Assertion macros shared by the checker of the ordered queue.
// No dependencies; included by bare file name.
`ifndef ORDERED_QUEUE_REMOVE_BY_KEY_DEFINES_SVH
`define ORDERED_QUEUE_REMOVE_BY_KEY_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define OQRK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ordered queue assertion failed");

// Next-cycle implication, inactive during reset.
`define OQRK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ordered queue assertion failed");

`endif

### src/oqrk_pkg.sv
// Shared sizes, codes and command type of the ordered queue.
// No dependencies; used by every module of the block.
package oqrk_pkg;

	localparam int DEPTH    = 16;
	localparam int ID_WIDTH = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// port field widths
	localparam int PID_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE     = 2'd0,
		STS_FULL     = 2'd1,
		STS_NO_MATCH = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture item and compare against all cells
		logic exec;   // apply the item and load the result register
	} ctl_cmd_t;

endpackage

### src/oqrk_ctrl.sv
// Controller of the ordered queue: item sequencing and result valid.
// Depends on oqrk_pkg.
module oqrk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output oqrk_pkg::ctl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
					if (m_tready) m_tvalid_q <= 1'b0;
				end
				ST_EXEC: begin
					// hold until the result register is free
					if (out_free) begin
						state_q    <= ST_IDLE;
						m_tvalid_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					m_tvalid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

### src/oqrk_datapath.sv
// Datapath of the ordered queue: row of identifier cells, count,
// parallel key compare, gap-closing shift and result register. Depends on oqrk_pkg.
module oqrk_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  oqrk_pkg::ctl_cmd_t                cmd,
	input  logic                              in_cmd,
	input  logic [oqrk_pkg::PID_W-1:0]        in_pid,
	output logic [oqrk_pkg::STATUS_W-1:0]     out_status,
	output logic [oqrk_pkg::COUNT_W-1:0]      out_count
);

	logic [oqrk_pkg::ID_WIDTH-1:0] cells_q [oqrk_pkg::DEPTH];
	logic [oqrk_pkg::ID_WIDTH-1:0] cells_d [oqrk_pkg::DEPTH];
	logic [oqrk_pkg::CNT_W-1:0]    count_q;
	logic [oqrk_pkg::CNT_W-1:0]    count_d;
	logic [oqrk_pkg::ID_WIDTH-1:0] key_s1;
	logic                          cmd_s1;
	logic [oqrk_pkg::DEPTH-1:0]    match_s1;
	logic [oqrk_pkg::DEPTH-1:0]    first_hit;
	logic [oqrk_pkg::DEPTH-1:0]    shift_mask;
	logic                          hit_any;
	logic                          full;
	oqrk_pkg::status_t             status_d;
	logic [oqrk_pkg::STATUS_W-1:0] status_q;
	logic [oqrk_pkg::COUNT_W-1:0]  count_out_q;

	assign full      = (count_q == oqrk_pkg::CNT_W'(oqrk_pkg::DEPTH));
	assign hit_any   = |match_s1;
	// isolate the match nearest the head, then mark it and every later cell
	assign first_hit  = match_s1 & (~match_s1 + oqrk_pkg::DEPTH'(1));
	assign shift_mask = ~(first_hit - oqrk_pkg::DEPTH'(1));

	always_comb begin
		cells_d  = cells_q;
		count_d  = count_q;
		status_d = oqrk_pkg::STS_DONE;
		if (oqrk_pkg::cmd_t'(cmd_s1) == oqrk_pkg::CMD_APPEND) begin
			if (full) begin
				status_d = oqrk_pkg::STS_FULL;
			end else begin
				for (int i = 0; i < oqrk_pkg::DEPTH; i++) begin
					if (oqrk_pkg::IDX_W'(i) == count_q[oqrk_pkg::IDX_W-1:0])
						cells_d[i] = key_s1;
				end
				count_d = count_q + oqrk_pkg::CNT_W'(1);
			end
		end else begin
			if (!hit_any) begin
				status_d = oqrk_pkg::STS_NO_MATCH;
			end else begin
				// close the gap: every cell from the hit onward takes its successor
				for (int i = 0; i < oqrk_pkg::DEPTH - 1; i++) begin
					if (shift_mask[i]) cells_d[i] = cells_q[i + 1];
				end
				count_d = count_q - oqrk_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1 <= in_cmd;
			key_s1 <= oqrk_pkg::ID_WIDTH'(in_pid);
			for (int i = 0; i < oqrk_pkg::DEPTH; i++) begin
				match_s1[i] <= (cells_q[i] == oqrk_pkg::ID_WIDTH'(in_pid)) &&
				               (oqrk_pkg::CNT_W'(i) < count_q);
			end
		end
		if (cmd.exec) begin
			cells_q     <= cells_d;
			status_q    <= status_d;
			count_out_q <= oqrk_pkg::COUNT_W'(count_d);
		end
	end

	assign out_status = status_q;
	assign out_count  = count_out_q;

endmodule

### src/ordered_queue_remove_by_key.sv
// Top level of the ordered queue with append at tail and remove by key.
// Depends on oqrk_pkg, oqrk_ctrl and oqrk_datapath.
//
//  channel | dir | tdata                        | tuser
//  s_      | in  | [15:0] pid_value             | [0] command
//  m_      | out | [4:0] entry_count, [7:5] zero| [1:0] status
//
// Each item first has its key compared against every cell at once, then
// appends to or shifts the row and loads the result register.
// The next item is taken while the result still waits in its register.
// Reset clears the count and the handshake state; cells need no clearing.
// A stalled result holds the block in its apply step until the register frees.
module ordered_queue_remove_by_key (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [oqrk_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] pid_value
	input  logic                              s_tuser,   // [0] command
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [oqrk_pkg::M_TDATA_W-1:0]    m_tdata,   // [4:0] entry_count, [7:5] zero
	output logic [oqrk_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);

	oqrk_pkg::ctl_cmd_t               cmd;
	logic [oqrk_pkg::COUNT_W-1:0]     count;

	oqrk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	oqrk_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_cmd     (s_tuser),
		.in_pid     (s_tdata[oqrk_pkg::PID_W-1:0]),
		.out_status (m_tuser),
		.out_count  (count)
	);

	assign m_tdata = oqrk_pkg::M_TDATA_W'(count);

endmodule

### src/oqrk_checker.sv
// Port-level checker of the ordered queue, bound to the top level.
// Depends on oqrk_pkg and ordered_queue_remove_by_key_defines.svh.
`include "ordered_queue_remove_by_key_defines.svh"

module oqrk_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [oqrk_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic [oqrk_pkg::STATUS_W-1:0]     m_tuser
);

	logic [oqrk_pkg::COUNT_W-1:0] cnt;

	assign cnt = m_tdata[oqrk_pkg::COUNT_W-1:0];

	// a full append can only report a store at capacity
	`OQRK_ASSERT_IMP(a_full_at_depth, clk, arst_n,
		m_tvalid && (m_tuser == oqrk_pkg::STS_FULL),
		cnt == oqrk_pkg::COUNT_W'(oqrk_pkg::DEPTH))
	`OQRK_ASSERT_IMP(a_count_bound, clk, arst_n,
		m_tvalid, cnt <= oqrk_pkg::COUNT_W'(oqrk_pkg::DEPTH))
	// one item in flight: an accepted item is never followed by another at once
	`OQRK_ASSERT_NXT(a_one_in_flight, clk, arst_n,
		s_tvalid && s_tready, !s_tready)
	`OQRK_ASSERT_NXT(a_result_holds, clk, arst_n,
		m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ordered_queue_remove_by_key oqrk_checker u_oqrk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### tb/ordered_queue_remove_by_key_tb.sv
// Testbench for ordered_queue_remove_by_key: directed, back-pressure and random items,
// each result checked against a queue model kept in the testbench.
// Depends on oqrk_pkg and the ordered_queue_remove_by_key RTL.
`timescale 1ns / 100ps

module ordered_queue_remove_by_key_tb;

	localparam int          HOLD_CYCLES  = 80;
	localparam int          DRAIN_LIMIT  = 2000;
	localparam logic [31:0] ID_MASK      = 32'((64'd1 << oqrk_pkg::ID_WIDTH) - 1);

	typedef struct packed {
		oqrk_pkg::status_t status;
		logic [4:0]        count;
	} queue_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [oqrk_pkg::S_TDATA_W-1:0]   s_tdata;    // [15:0] pid_value
	logic                             s_tuser;    // [0] command
	logic                             m_tvalid;
	logic                             m_tready;
	logic [oqrk_pkg::M_TDATA_W-1:0]   m_tdata;    // [4:0] entry_count, [7:5] zero
	logic [oqrk_pkg::STATUS_W-1:0]    m_tuser;    // [1:0] status

	// model of the list and the results still owed by the block
	logic [31:0]     held_ids[$];
	queue_result_t   owed_results[$];
	logic [15:0]     key_pool[8];

	logic            idle_en;
	logic            hold_req;
	int unsigned     mismatches;
	int unsigned     results_seen;
	int unsigned     items_sent;
	int unsigned     full_drops;
	int unsigned     remove_misses;
	int unsigned     peak_count;

	ordered_queue_remove_by_key u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results still owed", owed_results.size());
		$display("ordered_queue_remove_by_key: mismatch");
		$finish;
	end

	// Apply one accepted item to the list model and queue its result.
	function automatic void apply_list_item(input oqrk_pkg::cmd_t cmd,
			input logic [15:0] pid);
		logic [31:0]     key;
		int              hit;
		queue_result_t   res;
		key = {16'd0, pid} & ID_MASK;
		hit = -1;
		res.status = oqrk_pkg::STS_DONE;
		if (cmd == oqrk_pkg::CMD_APPEND) begin
			if (held_ids.size() >= oqrk_pkg::DEPTH) begin
				res.status = oqrk_pkg::STS_FULL;
				full_drops++;
			end else begin
				held_ids.push_back(key);
			end
		end else begin
			foreach (held_ids[i])
				if (hit < 0 && held_ids[i] == key)
					hit = i;
			if (hit < 0) begin
				res.status = oqrk_pkg::STS_NO_MATCH;
				remove_misses++;
			end else begin
				held_ids.delete(hit);
			end
		end
		res.count = 5'(held_ids.size());
		if (held_ids.size() > peak_count)
			peak_count = held_ids.size();
		owed_results.push_back(res);
		items_sent++;
	endfunction

	task automatic send_item(input oqrk_pkg::cmd_t cmd, input logic [15:0] pid);
		if (idle_en && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 18);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= pid;
		do @(posedge clk); while (!s_tready);
		apply_list_item(cmd, pid);
	endtask

	// Alternate append-heavy and remove-heavy stretches so the count sweeps empty to full.
	task automatic run_random_items(input int unsigned n);
		logic [15:0]      pid;
		oqrk_pkg::cmd_t   cmd;
		int unsigned      append_pct;
		for (int unsigned i = 0; i < n; i++) begin
			append_pct = ((i / 40) % 2 == 0) ? 72 : 30;
			cmd = ($urandom_range(0, 99) < append_pct) ? oqrk_pkg::CMD_APPEND
				: oqrk_pkg::CMD_REMOVE;
			if (cmd == oqrk_pkg::CMD_REMOVE && held_ids.size() != 0 &&
					$urandom_range(0, 9) < 7)
				pid = held_ids[$urandom_range(0, held_ids.size() - 1)][15:0];
			else if ($urandom_range(0, 1) == 1)
				pid = key_pool[$urandom_range(0, 7)];
			else
				pid = 16'($urandom);
			send_item(cmd, pid);
		end
	endtask

	task automatic test_corner_cases;
		send_item(oqrk_pkg::CMD_REMOVE, 16'h1234);    // remove from empty list
		send_item(oqrk_pkg::CMD_APPEND, 16'h0000);
		send_item(oqrk_pkg::CMD_APPEND, 16'hFFFF);
		send_item(oqrk_pkg::CMD_APPEND, 16'h0000);
		send_item(oqrk_pkg::CMD_APPEND, 16'hA5A5);
		send_item(oqrk_pkg::CMD_REMOVE, 16'h0000);    // head goes, later duplicate stays
		send_item(oqrk_pkg::CMD_REMOVE, 16'h0000);    // now in the middle
		send_item(oqrk_pkg::CMD_REMOVE, 16'hA5A5);    // tail
		send_item(oqrk_pkg::CMD_REMOVE, 16'h5A5A);    // no match
		send_item(oqrk_pkg::CMD_REMOVE, 16'hFFFF);    // last entry
	endtask

	task automatic test_fill_to_full;
		logic [15:0] first_id;
		first_id = 16'($urandom);
		send_item(oqrk_pkg::CMD_APPEND, first_id);
		while (held_ids.size() < oqrk_pkg::DEPTH)
			send_item(oqrk_pkg::CMD_APPEND, 16'($urandom));
		send_item(oqrk_pkg::CMD_APPEND, first_id);    // dropped while full
		send_item(oqrk_pkg::CMD_APPEND, 16'($urandom));
	endtask

	// Stall the result side long enough that the block fills and stops taking items.
	task automatic test_backpressure;
		hold_req <= 1'b1;
		run_random_items(24);
	endtask

	task automatic test_burst;
		idle_en = 1'b0;
		run_random_items(100);
		idle_en = 1'b1;
	endtask

	task automatic test_random;
		run_random_items(260);
	endtask

	// Result side: random stalls, plus one long hold on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end
			m_tready <= idle_en ? ($urandom_range(0, 99) >= 18) : 1'b1;
		end
	end

	task automatic note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s expected %0h got %0h", results_seen, what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				note_mismatch("unexpected result, status", 0, m_tuser);
			end else begin
				want = owed_results.pop_front();
				if (m_tuser !== want.status)
					note_mismatch("status", want.status, m_tuser);
				if (m_tdata[4:0] !== want.count)
					note_mismatch("entry_count", want.count, m_tdata[4:0]);
				if (m_tdata[7:5] !== 3'd0)
					note_mismatch("tdata fill", 0, m_tdata[7:5]);
			end
			results_seen++;
		end
	end

	initial begin
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = oqrk_pkg::CMD_APPEND;
		arst_n        = 1'b0;
		idle_en       = 1'b1;
		hold_req      = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
		items_sent    = 0;
		full_drops    = 0;
		remove_misses = 0;
		peak_count    = 0;
		foreach (key_pool[i])
			key_pool[i] = 16'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_fill_to_full();
		test_backpressure();
		test_burst();
		test_random();
		s_tvalid <= 1'b0;

		for (int n = 0; n < DRAIN_LIMIT && owed_results.size() != 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (owed_results.size() != 0)
			note_mismatch("results never arrived, count", 0, owed_results.size());

		$display("%0d items sent, %0d results checked, %0d dropped when full, %0d removes missed",
			items_sent, results_seen, full_drops, remove_misses);
		$display("peak entry count %0d of %0d, one long output stall, %0d mismatches",
			peak_count, oqrk_pkg::DEPTH, mismatches);
		if (mismatches == 0)
			$display("ordered_queue_remove_by_key: match");
		else
			$display("ordered_queue_remove_by_key: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/oqrk_pkg.sv
src/oqrk_ctrl.sv
src/oqrk_datapath.sv
src/ordered_queue_remove_by_key.sv
src/oqrk_checker.sv
tb/ordered_queue_remove_by_key_tb.sv
